// ===== rtl/lltok_pkg.sv =====
// ----------------------------------------------------------------------------
// lltok_pkg
// Shared types, token codes and the keyword table for the layout tokenizer.
// ----------------------------------------------------------------------------
package lltok_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int LineBitsDefault     = 16;

  localparam int KwCount   = 20;
  localparam int FifoDepth = 4;

  // token kinds
  localparam logic [4:0] TokError    = 5'd0;
  localparam logic [4:0] TokEof      = 5'd1;
  localparam logic [4:0] TokNumber   = 5'd2;
  localparam logic [4:0] TokString   = 5'd3;
  localparam logic [4:0] TokLBrace   = 5'd4;
  localparam logic [4:0] TokRBrace   = 5'd5;
  localparam logic [4:0] TokLBracket = 5'd6;
  localparam logic [4:0] TokRBracket = 5'd7;
  localparam logic [4:0] TokColon    = 5'd8;
  localparam logic [4:0] TokComma    = 5'd9;
  localparam logic [4:0] TokKwBase   = 5'd10;

  // error kinds
  localparam logic [1:0] ErrNone         = 2'd0;
  localparam logic [1:0] ErrUnterminated = 2'd1;
  localparam logic [1:0] ErrUnknownKw    = 2'd2;
  localparam logic [1:0] ErrUnexpected   = 2'd3;

  // characters
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChNewline  = 8'h0A;
  localparam logic [7:0] ChReturn   = 8'h0D;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChHash     = 8'h23;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChLBrace   = 8'h7B;
  localparam logic [7:0] ChRBrace   = 8'h7D;

  // keywords, alphabetical; text is right-justified in 80 bits
  localparam logic [79:0] KwText [KwCount] = '{
    "button", "checklist", "column", "command", "config", "console",
    "enable", "exit", "false", "hline", "label", "list", "name", "null",
    "row", "textbox", "true", "variable", "vline", "window"
  };
  localparam logic [3:0] KwLen [KwCount] = '{
    4'd6, 4'd9, 4'd6, 4'd7, 4'd6, 4'd7, 4'd6, 4'd4, 4'd5, 4'd5,
    4'd5, 4'd4, 4'd4, 4'd4, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd6
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last_of_run;
  } out_beat_t;

  // up to two results of one byte, packed toward r0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_beat_t r0;
    out_beat_t r1;
  } res_pair_t;

  // character pos of keyword idx, zero past its end
  function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [3:0] pos);
    logic [79:0] txt;
    logic [3:0]  len;
    logic [6:0]  sh;
    txt = KwText[idx];
    len = KwLen[idx];
    sh  = {len - pos - 4'd1, 3'b000};
    kw_char = 8'h00;
    if (pos < len) begin
      kw_char = txt[sh +: 8];
    end
  endfunction

  function automatic logic [15:0] clamp16(input logic [32:0] v);
    clamp16 = (v > 33'h0FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== rtl/lltok_fifo.sv =====
// ----------------------------------------------------------------------------
// lltok_fifo
// Result queue: up to two results in and, while ready, one beat out per cycle.
// ----------------------------------------------------------------------------
module lltok_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lltok_pkg::res_pair_t  push_i,
  output logic                  has_room_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output lltok_pkg::out_beat_t  out_data_o
);
  import lltok_pkg::*;

  localparam int PtrBits = $clog2(FifoDepth);
  localparam int CntBits = PtrBits + 1;

  out_beat_t          mem_q [FifoDepth];
  logic [PtrBits-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               pop;
  logic [CntBits-1:0] n_push;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign has_room_o  = (cnt_q <= CntBits'(FifoDepth - 2));
  assign n_push      = CntBits'(push_i.v0) + CntBits'(push_i.v1);

  always_comb begin
    rd_d  = pop ? rd_q + PtrBits'(1) : rd_q;
    wr_d  = wr_q + n_push[PtrBits-1:0];
    cnt_d = cnt_q + n_push - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_q + PtrBits'(1)] <= push_i.r1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(FifoDepth))
    else $error("result queue count out of range");
  a_push_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> push_i.v0)
    else $error("second result pushed without first");
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> cnt_q <= CntBits'(FifoDepth - 2))
    else $error("result queue overflow");
`endif

endmodule

// ===== rtl/lltok_scan.sv =====
// ----------------------------------------------------------------------------
// lltok_scan
// Scanner state and per-byte step: modes, keyword match lanes, counters.
// ----------------------------------------------------------------------------
module lltok_scan #(
  parameter int PositionBits = lltok_pkg::PositionBitsDefault,
  parameter int LineBits     = lltok_pkg::LineBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  lltok_pkg::in_beat_t  in_i,
  output lltok_pkg::res_pair_t res_o
);
  import lltok_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle,
    ModeComment,
    ModeWord,
    ModeNumber,
    ModeString
  } mode_e;

  mode_e                   mode_q, mode_d;
  logic [PositionBits-1:0] pos_q, pos_d, ls_q, ls_d;
  logic [LineBits-1:0]     line_q, line_d, line_up;
  logic [KwCount-1:0]      mask_q, mask_d;
  logic [3:0]              wlen_q, wlen_d;
  logic                    dot_q, dot_d;

  logic [7:0]              c;
  logic                    is_alpha, is_digit;
  logic [KwCount-1:0]      trie_base, next_mask;
  logic [3:0]              trie_k;
  logic [PositionBits:0]   len_open, len_str;
  logic [15:0]             p16, ls16, line16;
  logic [4:0]              word_kind;
  logic                    word_hit;
  logic                    a_v, b_v, idle_run;
  out_beat_t               a_r, b_r;

  assign c        = in_i.text_byte;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  assign is_digit = (c >= 8'h30 && c <= 8'h39);
  assign len_open = {1'b0, pos_q} - {1'b0, ls_q};
  assign len_str  = len_open + (PositionBits+1)'(1);
  assign p16      = clamp16(33'(pos_q));
  assign ls16     = clamp16(33'(ls_q));
  assign line16   = clamp16(33'(line_q));
  assign line_up  = (line_q == '1) ? line_q : line_q + LineBits'(1);

  // keyword lanes: continue the word or start one from all candidates
  always_comb begin
    if (mode_q == ModeWord) begin
      trie_base = mask_q;
      trie_k    = wlen_q;
    end else begin
      trie_base = '1;
      trie_k    = '0;
    end
    for (int i = 0; i < KwCount; i++) begin
      next_mask[i] = trie_base[i] && (trie_k < KwLen[i]) &&
                     (kw_char(5'(i), trie_k) == c);
    end
  end

  // exact match lane, at most one
  always_comb begin
    word_hit  = 1'b0;
    word_kind = TokError;
    for (int i = 0; i < KwCount; i++) begin
      if (mask_q[i] && (KwLen[i] == wlen_q)) begin
        word_hit  = 1'b1;
        word_kind = TokKwBase + 5'(i);
      end
    end
    if (wlen_q < 4'd2) begin
      word_hit = 1'b0;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    pos_d    = (pos_q == '1) ? pos_q : pos_q + PositionBits'(1);
    ls_d     = ls_q;
    line_d   = line_q;
    mask_d   = mask_q;
    wlen_d   = wlen_q;
    dot_d    = dot_q;
    idle_run = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_r      = '0;
    b_r      = '0;
    a_r.line_number = line16;
    b_r.line_number = line16;

    if (in_i.end_of_text) begin
      pos_d = pos_q;
      unique case (mode_q)
        ModeWord: begin
          a_v = 1'b1;
          a_r.token_kind = word_hit ? word_kind : TokError;
          a_r.error_kind = word_hit ? ErrNone : ErrUnknownKw;
        end
        ModeNumber: begin
          a_v = 1'b1;
          a_r.token_kind = TokNumber;
        end
        ModeString: begin
          a_v = 1'b1;
          a_r.token_kind = TokError;
          a_r.error_kind = ErrUnterminated;
        end
        default: ;
      endcase
      a_r.token_start  = ls16;
      a_r.token_length = clamp16(33'(len_open));
      mode_d = ModeIdle;
      b_v = 1'b1;
      b_r.token_kind   = TokEof;
      b_r.token_start  = p16;
      b_r.token_length = 16'd0;
    end else begin
      unique case (mode_q)
        ModeIdle: idle_run = 1'b1;
        ModeComment: begin
          if (c == ChNewline) begin
            idle_run = 1'b1;
          end
        end
        ModeWord: begin
          if (is_alpha || is_digit) begin
            mask_d = next_mask;
            wlen_d = (wlen_q == 4'hF) ? wlen_q : wlen_q + 4'd1;
          end else begin
            a_v = 1'b1;
            a_r.token_kind = word_hit ? word_kind : TokError;
            a_r.error_kind = word_hit ? ErrNone : ErrUnknownKw;
            idle_run = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit) begin
            dot_d = dot_q;
          end else if (c == ChDot && !dot_q) begin
            dot_d = 1'b1;
          end else begin
            a_v = 1'b1;
            a_r.token_kind = TokNumber;
            idle_run = 1'b1;
          end
        end
        ModeString: begin
          if (c == ChQuote) begin
            mode_d = ModeIdle;
            a_v = 1'b1;
            a_r.token_kind   = TokString;
            a_r.token_length = clamp16(33'(len_str));
          end else if (c == ChNewline) begin
            line_d = line_up;
          end
        end
        default: idle_run = 1'b1;
      endcase
      a_r.token_start = ls16;
      if (!(mode_q == ModeString)) begin
        a_r.token_length = clamp16(33'(len_open));
      end

      if (idle_run) begin
        mode_d = ModeIdle;
        b_r.token_start  = p16;
        b_r.token_length = 16'd1;
        priority if (c == ChSpace || c == ChReturn || c == ChTab) begin
          mode_d = ModeIdle;
        end else if (c == ChNewline) begin
          line_d = line_up;
        end else if (c == ChHash) begin
          mode_d = ModeComment;
        end else if (c == ChQuote) begin
          mode_d = ModeString;
          ls_d   = pos_q;
        end else if (c == ChLBrace) begin
          b_v = 1'b1;
          b_r.token_kind = TokLBrace;
        end else if (c == ChRBrace) begin
          b_v = 1'b1;
          b_r.token_kind = TokRBrace;
        end else if (c == ChLBracket) begin
          b_v = 1'b1;
          b_r.token_kind = TokLBracket;
        end else if (c == ChRBracket) begin
          b_v = 1'b1;
          b_r.token_kind = TokRBracket;
        end else if (c == ChColon) begin
          b_v = 1'b1;
          b_r.token_kind = TokColon;
        end else if (c == ChComma) begin
          b_v = 1'b1;
          b_r.token_kind = TokComma;
        end else if (is_alpha) begin
          mode_d = ModeWord;
          ls_d   = pos_q;
          mask_d = next_mask;
          wlen_d = 4'd1;
        end else if (is_digit) begin
          mode_d = ModeNumber;
          ls_d   = pos_q;
          dot_d  = 1'b0;
        end else begin
          b_v = 1'b1;
          b_r.token_kind = TokError;
          b_r.error_kind = ErrUnexpected;
        end
      end
    end
  end

  // pack results toward r0, mark the final one
  always_comb begin
    res_o = '0;
    if (a_v) begin
      res_o.v0 = fire_i;
      res_o.v1 = fire_i && b_v;
      res_o.r0 = a_r;
      res_o.r1 = b_r;
      res_o.r0.last_of_run = !b_v;
      res_o.r1.last_of_run = 1'b1;
    end else begin
      res_o.v0 = fire_i && b_v;
      res_o.r0 = b_r;
      res_o.r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      pos_q  <= '0;
      ls_q   <= '0;
      line_q <= LineBits'(1);
      mask_q <= '1;
      wlen_q <= '0;
      dot_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ls_q   <= ls_d;
      line_q <= line_d;
      mask_q <= mask_d;
      wlen_q <= wlen_d;
      dot_q  <= dot_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && in_i.end_of_text) |=> mode_q == ModeIdle)
    else $error("scanner not idle after end of text");
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line count reached zero");
  a_eot_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && in_i.end_of_text) |-> (res_o.v1 ? res_o.r1.token_kind == TokEof
                                                : res_o.r0.token_kind == TokEof))
    else $error("end of text without final eof token");
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |-> !res_o.v0 && !res_o.v1)
    else $error("result produced without an input beat");
`endif

endmodule

// ===== rtl/layout_language_tokenizer.sv =====
// ----------------------------------------------------------------------------
// layout_language_tokenizer
// Streaming tokenizer for a small layout language: one text byte per beat
// in, one token per beat out.
// A token enters the result queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the output takes one beat per cycle;
// a byte that yields two tokens uses two output beats, and input stalls when
// the four-entry result queue has fewer than two free slots.
// Reset: scanner idle, position 0, line 1, result queue empty.
// ----------------------------------------------------------------------------
module layout_language_tokenizer #(
  parameter int PositionBits = lltok_pkg::PositionBitsDefault,
  parameter int LineBits     = lltok_pkg::LineBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lltok_pkg::in_beat_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lltok_pkg::out_beat_t out_data_o
);
  import lltok_pkg::*;

  logic      in_fire;
  logic      room;
  res_pair_t res;

  assign in_ready_o = room;
  assign in_fire    = in_valid_i && room;

  lltok_scan #(
    .PositionBits(PositionBits),
    .LineBits    (LineBits)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(in_fire),
    .in_i  (in_data_i),
    .res_o (res)
  );

  lltok_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res),
    .has_room_o (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== tb/layout_language_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// layout_language_tokenizer_tb
// Feeds source text to the tokenizer one byte per beat. A short directed text
// comes first, then random well-formed pieces mixed with noise and
// end-of-text marks. A scoreboard keeps its own scanner state, works out
// the tokens due for every accepted byte, and checks each output beat field
// by field in order. The sender runs in bursts, with gaps in some phases. The
// receiver stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module layout_language_tokenizer_tb;
  import lltok_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_COMMENT,
    SCAN_WORD,
    SCAN_NUMBER,
    SCAN_STRING
  } scan_mode_e;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  class token_checker;
    out_beat_t   tokens_due[$];
    int          errors;
    scan_mode_e  mode;
    logic [15:0] lex_start;
    logic [15:0] byte_pos;
    logic [15:0] line_no;
    logic [7:0]  word_buf [10];
    int          word_cnt;
    logic        frac_dot;

    function new();
      errors    = 0;
      mode      = SCAN_IDLE;
      lex_start = '0;
      byte_pos  = '0;
      line_no   = 16'd1;
      word_cnt  = 0;
      frac_dot  = 1'b0;
    endfunction

    static function string keyword_text(int idx);
      case (idx)
        0:  return "button";
        1:  return "checklist";
        2:  return "column";
        3:  return "command";
        4:  return "config";
        5:  return "console";
        6:  return "enable";
        7:  return "exit";
        8:  return "false";
        9:  return "hline";
        10: return "label";
        11: return "list";
        12: return "name";
        13: return "null";
        14: return "row";
        15: return "textbox";
        16: return "true";
        17: return "variable";
        18: return "vline";
        19: return "window";
        default: return "";
      endcase
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void bump_line();
      if (line_no != 16'hFFFF) line_no++;
    endfunction

    function void emit(logic [4:0] kind, logic [1:0] err, logic [15:0] start,
                       logic [16:0] len);
      out_beat_t t;
      t.token_kind   = kind;
      t.error_kind   = err;
      t.token_start  = start;
      t.token_length = (len > 17'h0FFFF) ? 16'hFFFF : len[15:0];
      t.line_number  = line_no;
      t.last_of_run  = 1'b0;
      tokens_due.push_back(t);
    endfunction

    function void add_letter(logic [7:0] c);
      if (word_cnt < 10) word_buf[word_cnt] = c;
      if (word_cnt < 15) word_cnt++;
    endfunction

    function void close_word(logic [15:0] p);
      int    hit;
      bit    same;
      string kw;
      hit = -1;
      for (int i = 0; i < KwCount && hit < 0; i++) begin
        kw   = keyword_text(i);
        same = (kw.len() == word_cnt);
        for (int j = 0; same && j < kw.len(); j++) begin
          if (kw[j] != word_buf[j]) same = 0;
        end
        if (same) hit = i;
      end
      mode = SCAN_IDLE;
      if (hit >= 0) begin
        emit(TokKwBase + 5'(hit), ErrNone, lex_start, {1'b0, p} - {1'b0, lex_start});
      end else begin
        emit(TokError, ErrUnknownKw, lex_start, {1'b0, p} - {1'b0, lex_start});
      end
    endfunction

    function void scan_from_idle(logic [7:0] c, logic [15:0] p);
      case (c)
        ChSpace, ChTab, ChReturn: ;
        ChNewline: bump_line();
        ChHash:    mode = SCAN_COMMENT;
        ChQuote: begin
          mode      = SCAN_STRING;
          lex_start = p;
        end
        ChLBrace:   emit(TokLBrace, ErrNone, p, 17'd1);
        ChRBrace:   emit(TokRBrace, ErrNone, p, 17'd1);
        ChLBracket: emit(TokLBracket, ErrNone, p, 17'd1);
        ChRBracket: emit(TokRBracket, ErrNone, p, 17'd1);
        ChColon:    emit(TokColon, ErrNone, p, 17'd1);
        ChComma:    emit(TokComma, ErrNone, p, 17'd1);
        default: begin
          if (is_letter(c)) begin
            mode      = SCAN_WORD;
            lex_start = p;
            word_cnt  = 0;
            add_letter(c);
          end else if (is_digit(c)) begin
            mode      = SCAN_NUMBER;
            lex_start = p;
            frac_dot  = 1'b0;
          end else begin
            emit(TokError, ErrUnexpected, p, 17'd1);
          end
        end
      endcase
    endfunction

    function void take_byte(in_beat_t b);
      int          n0;
      logic [15:0] p;
      logic [7:0]  c;
      n0 = tokens_due.size();
      p  = byte_pos;
      c  = b.text_byte;
      if (b.end_of_text) begin
        case (mode)
          SCAN_WORD:   close_word(p);
          SCAN_NUMBER: emit(TokNumber, ErrNone, lex_start, {1'b0, p} - {1'b0, lex_start});
          SCAN_STRING: emit(TokError, ErrUnterminated, lex_start,
                            {1'b0, p} - {1'b0, lex_start});
          default: ;
        endcase
        mode = SCAN_IDLE;
        emit(TokEof, ErrNone, p, 17'd0);
      end else begin
        case (mode)
          SCAN_COMMENT: begin
            if (c == ChNewline) begin
              mode = SCAN_IDLE;
              scan_from_idle(c, p);
            end
          end
          SCAN_WORD: begin
            if (is_letter(c) || is_digit(c)) begin
              add_letter(c);
            end else begin
              close_word(p);
              scan_from_idle(c, p);
            end
          end
          SCAN_NUMBER: begin
            if (is_digit(c)) begin
            end else if (c == ChDot && !frac_dot) begin
              frac_dot = 1'b1;
            end else begin
              mode = SCAN_IDLE;
              emit(TokNumber, ErrNone, lex_start, {1'b0, p} - {1'b0, lex_start});
              scan_from_idle(c, p);
            end
          end
          SCAN_STRING: begin
            if (c == ChQuote) begin
              mode = SCAN_IDLE;
              emit(TokString, ErrNone, lex_start, {1'b0, p} - {1'b0, lex_start} + 17'd1);
            end else if (c == ChNewline) begin
              bump_line();
            end
          end
          default: scan_from_idle(c, p);
        endcase
        if (byte_pos != 16'hFFFF) byte_pos++;
      end
      if (tokens_due.size() > n0) tokens_due[tokens_due.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string what);
      if (errors < 60) $display("mismatch: %s", what);
      errors++;
    endtask

    task match_token(out_beat_t got);
      out_beat_t want;
      if (tokens_due.size() == 0) begin
        report($sformatf("token kind %0d at %0d with none due", got.token_kind,
                         got.token_start));
        return;
      end
      want = tokens_due.pop_front();
      if (got.token_kind !== want.token_kind)
        report($sformatf("token_kind %0d, want %0d", got.token_kind, want.token_kind));
      if (got.error_kind !== want.error_kind)
        report($sformatf("error_kind %0d, want %0d", got.error_kind, want.error_kind));
      if (got.token_start !== want.token_start)
        report($sformatf("token_start %0d, want %0d", got.token_start, want.token_start));
      if (got.token_length !== want.token_length)
        report($sformatf("token_length %0d, want %0d", got.token_length,
                         want.token_length));
      if (got.line_number !== want.line_number)
        report($sformatf("line_number %0d, want %0d", got.line_number, want.line_number));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0b, want %0b", got.last_of_run, want.last_of_run));
    endtask

    task leftover_check();
      if (tokens_due.size() != 0)
        report($sformatf("%0d tokens never came out", tokens_due.size()));
    endtask
  endclass

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  token_checker chk = new();

  rx_mode_e    rx_mode     = RX_FREE;
  int          holds_asked = 0;
  int          holds_done  = 0;
  int          hold_left   = 0;
  logic [11:0] rx_mask     = '0;
  int          rx_idx      = 0;
  bit          gaps_on     = 1'b0;
  int          burst_left  = 0;
  int          beats_sent  = 0;

  layout_language_tokenizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) chk.take_byte(in_data);
      if (out_valid_o && out_ready) chk.match_token(out_data_o);
    end
  end

  // receiver: long hold-off on request, else per-phase stall pattern
  always @(negedge clk_i) begin
    if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
        default: begin
          if (rx_idx == 0) rx_mask = 12'($urandom);
          out_ready <= rx_mask[rx_idx];
          rx_idx = (rx_idx + 1) % 12;
        end
      endcase
    end
  end

  task automatic send_beat(input logic [7:0] c, input logic eot);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk_i);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid              <= 1'b1;
    in_data.text_byte     <= c;
    in_data.end_of_text   <= eot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChReturn;
      default: return ChNewline;
    endcase
  endfunction

  function automatic logic [7:0] punct_byte();
    case ($urandom_range(0, 5))
      0:       return ChLBrace;
      1:       return ChRBrace;
      2:       return ChLBracket;
      3:       return ChRBracket;
      4:       return ChColon;
      default: return ChComma;
    endcase
  endfunction

  // one random lexical piece, mostly well formed
  task automatic send_piece();
    int         r;
    int         k;
    string      w;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      w = token_checker::keyword_text($urandom_range(0, KwCount - 1));
      k = $urandom_range(0, 9);
      if (k == 0) w = w.substr(0, w.len() - 2);
      else if (k == 1) w.putc(0, w[0] - 8'h20);
      else if (k == 2) w = {w, "7"};
      else if (k == 3) w = "q";
      send_text(w);
    end else if (r < 45) begin
      repeat ($urandom_range(1, 4)) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
      if ($urandom_range(0, 9) < 4) begin
        send_beat(ChDot, 1'b0);
        repeat ($urandom_range(0, 3)) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 9) == 0) send_text(".5");
      end
    end else if (r < 55) begin
      send_beat(ChQuote, 1'b0);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(32, 126));
        if (c == ChQuote) c = "x";
        if ($urandom_range(0, 9) == 0) c = ChNewline;
        send_beat(c, 1'b0);
      end
      if ($urandom_range(0, 99) < 92) send_beat(ChQuote, 1'b0);
      else send_beat(8'($urandom_range(0, 255)), 1'b1);
    end else if (r < 70) begin
      send_beat(punct_byte(), 1'b0);
    end else if (r < 78) begin
      send_beat(ChHash, 1'b0);
      repeat ($urandom_range(0, 8)) begin
        c = 8'($urandom_range(0, 255));
        if (c == ChNewline) c = ChSpace;
        send_beat(c, 1'b0);
      end
      send_beat(ChNewline, 1'b0);
    end else if (r < 85) begin
      repeat ($urandom_range(1, 3)) send_beat(blank_byte(), 1'b0);
    end else if (r < 96) begin
      repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
    if ($urandom_range(0, 9) < 6) send_beat(blank_byte(), 1'b0);
  endtask

  initial begin
    int phase_end;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-letter word then brace, second dot, number ended by bracket,
    // comment, string across a line, keyword, zero and 0xFF bytes,
    // unterminated string at end of text, bare end of text
    send_text("x{1.2.3]#c\n\"s\n\"row,");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("\"u");
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    wait_drained();

    phase_end = beats_sent;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          rx_mode = RX_FREE;
          gaps_on = 1'b0;
          holds_asked++;
        end
        1: begin
          rx_mode = RX_RANDOM;
          gaps_on = 1'b1;
        end
        2: begin
          rx_mode = RX_PATTERN;
          gaps_on = 1'b1;
        end
        3: begin
          rx_mode = RX_FREE;
          gaps_on = 1'b0;
        end
        4: begin
          rx_mode = RX_RANDOM;
          gaps_on = 1'b0;
        end
        default: begin
          rx_mode = RX_PATTERN;
          gaps_on = 1'b1;
        end
      endcase
      phase_end += 310;
      while (beats_sent < phase_end) send_piece();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    chk.leftover_check();
    if (chk.errors == 0) begin
      $display("layout_language_tokenizer_tb: clean");
    end else begin
      $display("layout_language_tokenizer_tb: errors");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("layout_language_tokenizer_tb: errors");
    $finish;
  end

endmodule
